/* rtl/wavpcm_pkg.sv */
package wavpcm_pkg;

  localparam int HEADER_WINDOW_DEF = 150;
  localparam int POS_W = 9;
  localparam int MARK_W = 8;

  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_SAMPLE    = 3'd1;
  localparam logic [2:0] KIND_NO_FMT    = 3'd2;
  localparam logic [2:0] KIND_NO_DATA   = 3'd3;
  localparam logic [2:0] KIND_BAD_WIDTH = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] sample;
    logic [15:0]        audio_format;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [31:0]        bytes_per_sec;
    logic [15:0]        block_align;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_size;
    logic               last;
  } result_item_t;

  typedef struct packed {
    logic       step;
    logic       clear;
    logic       set_width;
    logic       gather;
    logic       load;
    logic [2:0] kind;
  } dp_cmd_t;

  typedef struct packed {
    logic eof;
    logic fmt_seen;
    logic data_seen;
    logic header_point;
    logic window_end;
    logic width_ok;
    logic sample_full;
  } dp_status_t;

endpackage

/* rtl/wavpcm_ctrl.sv */
module wavpcm_ctrl
  import wavpcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_HEAD,
    ST_SAMPLES,
    ST_HALT
  } state_t;

  state_t state;
  state_t state_next;
  logic   halt;

  assign byte_ready = !result_valid || result_ready;

  always_comb begin
    cmd = '0;
    cmd.kind = KIND_HEADER;
    state_next = state;
    halt = 1'b0;
    cmd.step = byte_valid && byte_ready;
    if (cmd.step) begin
      case (state)
        ST_HEAD: begin
          if (status.header_point) begin
            if (!status.fmt_seen) begin
              cmd.load = 1'b1;
              cmd.kind = KIND_NO_FMT;
              halt = 1'b1;
            end else if (!status.width_ok) begin
              cmd.load = 1'b1;
              cmd.kind = KIND_BAD_WIDTH;
              halt = 1'b1;
            end else begin
              cmd.load = 1'b1;
              cmd.kind = KIND_HEADER;
              cmd.set_width = 1'b1;
              state_next = ST_SAMPLES;
            end
          end
          if (!cmd.load && (status.window_end || status.eof)) begin
            if (!status.fmt_seen) begin
              cmd.load = 1'b1;
              cmd.kind = KIND_NO_FMT;
              halt = 1'b1;
            end else if (!status.data_seen || status.eof) begin
              cmd.load = 1'b1;
              cmd.kind = KIND_NO_DATA;
              halt = 1'b1;
            end
          end
        end
        ST_SAMPLES: begin
          cmd.gather = 1'b1;
          if (status.sample_full) begin
            cmd.load = 1'b1;
            cmd.kind = KIND_SAMPLE;
          end
        end
        ST_HALT: begin
          cmd.load = 1'b0;
        end
        default: begin
          state_next = ST_HEAD;
        end
      endcase
      if (halt) begin
        state_next = ST_HALT;
      end
      if (status.eof) begin
        cmd.clear = 1'b1;
        state_next = ST_HEAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEAD;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/wavpcm_dpath.sv */
module wavpcm_dpath
  import wavpcm_pkg::*;
#(
  parameter int HEADER_WINDOW = HEADER_WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  byte_item_t   byte_item,
  input  dp_cmd_t      cmd,
  output dp_status_t   status,
  output result_item_t result_item
);

  localparam logic [7:0]  CHAR_F    = 8'h66;
  localparam logic [7:0]  CHAR_D    = 8'h64;
  localparam logic [31:0] EXT_TWO   = 32'hFFFF0000;
  localparam logic [31:0] EXT_THREE = 32'hFF000000;

  logic [POS_W-1:0]  pos;
  logic              fmt_seen;
  logic [MARK_W-1:0] fmt_pos;
  logic              data_seen;
  logic [MARK_W-1:0] data_pos;
  logic [31:0]       fmt_lo;
  logic [63:0]       rates;
  logic [31:0]       fmt_hi;
  logic [31:0]       payload_size;
  logic [2:0]        width;
  logic [31:0]       acc;
  logic [1:0]        gathered;

  logic              fmt_seen_next;
  logic [MARK_W-1:0] fmt_pos_next;
  logic              data_seen_next;
  logic [MARK_W-1:0] data_pos_next;
  logic [31:0]       fmt_lo_next;
  logic [63:0]       rates_next;
  logic [31:0]       fmt_hi_next;
  logic [31:0]       payload_size_next;
  logic [31:0]       acc_next;
  logic [31:0]       sample_val;

  logic [7:0]        b;
  logic              in_window;
  logic [POS_W-1:0]  fmt_off;
  logic [POS_W-1:0]  data_off;
  logic              fmt_cap;
  logic              data_in;
  logic [3:0]        k;
  logic [15:0]       ch;
  logic [15:0]       ba;
  logic [18:0]       c1;
  logic [18:0]       c2;
  logic [18:0]       c3;
  logic [18:0]       c4;
  logic [18:0]       c5;
  logic [18:0]       bx;
  logic [2:0]        width_calc;
  logic              sample_full;
  result_item_t      result_next;

  always_comb begin
    b = byte_item.data_byte;
    in_window = pos < POS_W'(HEADER_WINDOW);

    fmt_seen_next = fmt_seen;
    fmt_pos_next = fmt_pos;
    if (in_window && !fmt_seen && b == CHAR_F) begin
      fmt_seen_next = 1'b1;
      fmt_pos_next = pos[MARK_W-1:0];
    end
    data_seen_next = data_seen;
    data_pos_next = data_pos;
    if (in_window && !data_seen && b == CHAR_D) begin
      data_seen_next = 1'b1;
      data_pos_next = pos[MARK_W-1:0];
    end

    fmt_off = pos - POS_W'(fmt_pos);
    fmt_cap = fmt_seen && (pos > POS_W'(fmt_pos)) &&
              (fmt_off >= POS_W'(8)) && (fmt_off <= POS_W'(23));
    k = 4'(fmt_off - POS_W'(8));
    fmt_lo_next = fmt_lo;
    rates_next = rates;
    fmt_hi_next = fmt_hi;
    if (fmt_cap) begin
      if (k < 4'd4) begin
        fmt_lo_next[{k[1:0], 3'b000} +: 8] = b;
      end else if (k < 4'd12) begin
        rates_next[{3'(k - 4'd4), 3'b000} +: 8] = b;
      end else begin
        fmt_hi_next[{k[1:0], 3'b000} +: 8] = b;
      end
    end

    data_off = pos - POS_W'(data_pos);
    data_in = data_seen && (pos >= POS_W'(data_pos));
    payload_size_next = payload_size;
    if (data_in && data_off >= POS_W'(4) && data_off <= POS_W'(7)) begin
      payload_size_next[{data_off[1:0], 3'b000} +: 8] = b;
    end

    ch = fmt_lo_next[31:16];
    ba = fmt_hi_next[15:0];
    c1 = {3'b000, ch};
    c2 = {2'b00, ch, 1'b0};
    c3 = c2 + c1;
    c4 = {1'b0, ch, 2'b00};
    c5 = c4 + c1;
    bx = {3'b000, ba};
    if (ch == 16'd0 || bx < c1) begin
      width_calc = 3'd0;
    end else if (bx < c2) begin
      width_calc = 3'd1;
    end else if (bx < c3) begin
      width_calc = 3'd2;
    end else if (bx < c4) begin
      width_calc = 3'd3;
    end else if (bx < c5) begin
      width_calc = 3'd4;
    end else begin
      width_calc = 3'd0;
    end

    acc_next = acc | (32'(b) << {gathered, 3'b000});
    sample_full = ({1'b0, gathered} + 3'd1) == width;
    sample_val = acc_next;
    if (width == 3'd2 && acc_next[15]) begin
      sample_val = acc_next | EXT_TWO;
    end else if (width == 3'd3 && acc_next[23]) begin
      sample_val = acc_next | EXT_THREE;
    end

    status.eof = byte_item.end_of_file;
    status.fmt_seen = fmt_seen_next;
    status.data_seen = data_seen_next;
    status.header_point = data_in && data_off == POS_W'(7);
    status.window_end = pos == POS_W'(HEADER_WINDOW - 1);
    status.width_ok = width_calc != 3'd0;
    status.sample_full = sample_full;

    result_next = '0;
    result_next.kind = cmd.kind;
    result_next.last = byte_item.end_of_file;
    if (cmd.kind == KIND_HEADER) begin
      result_next.audio_format = fmt_lo_next[15:0];
      result_next.channels = ch;
      result_next.sample_rate = rates_next[31:0];
      result_next.bytes_per_sec = rates_next[63:32];
      result_next.block_align = ba;
      result_next.bits_per_sample = fmt_hi_next[31:16];
      result_next.data_size = payload_size_next;
    end else if (cmd.kind == KIND_SAMPLE) begin
      result_next.sample = sample_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_item <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.step && cmd.clear)) begin
      pos <= '0;
      fmt_seen <= 1'b0;
      fmt_pos <= '0;
      data_seen <= 1'b0;
      data_pos <= '0;
      fmt_lo <= '0;
      rates <= '0;
      fmt_hi <= '0;
      payload_size <= '0;
      width <= '0;
      acc <= '0;
      gathered <= '0;
    end else if (cmd.step) begin
      if (pos != '1) begin
        pos <= pos + POS_W'(1);
      end
      fmt_seen <= fmt_seen_next;
      fmt_pos <= fmt_pos_next;
      data_seen <= data_seen_next;
      data_pos <= data_pos_next;
      fmt_lo <= fmt_lo_next;
      rates <= rates_next;
      fmt_hi <= fmt_hi_next;
      payload_size <= payload_size_next;
      if (cmd.set_width) begin
        width <= width_calc;
      end
      if (cmd.gather) begin
        if (sample_full) begin
          acc <= '0;
          gathered <= '0;
        end else begin
          acc <= acc_next;
          gathered <= gathered + 2'd1;
        end
      end
    end
  end

endmodule

/* rtl/wav_header_and_pcm_unpacker.sv */
// WAV header reader and PCM sample unpacker.
// Input channel (byte_valid/byte_ready/byte_item): one file byte per transfer,
// end_of_file set on the final byte of a file; the next byte starts a new file.
// Output channel (result_valid/result_ready/result_item): at most one result
// per byte: the header record, a sample, or an error code, with last set when
// it comes from the end_of_file byte.
// A result sits in the output register in the cycle after its byte's
// transfer. Throughput: one byte per cycle while the output is not stalled, set by the byte step
// of the datapath (marker search, field capture and sample assembly all
// complete in the cycle the byte is taken).
// The sample width check compares block_align against channels times one to
// five in that same step.
// Stall: while a result waits in the output register and the receiver holds
// result_ready low, byte_ready is low; a free or draining output register
// keeps bytes flowing.
// Reset: empty output register, all header and sample state cleared, ready
// for the first byte of a file.
module wav_header_and_pcm_unpacker
  import wavpcm_pkg::*;
#(
  parameter int HEADER_WINDOW = HEADER_WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_ready,
  input  byte_item_t   byte_item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wavpcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  wavpcm_dpath #(
    .HEADER_WINDOW (HEADER_WINDOW)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .byte_item   (byte_item),
    .cmd         (cmd),
    .status      (status),
    .result_item (result_item)
  );

endmodule
